/* hw/rtl/ghs_pkg.sv */
// Package for the grouped hash set engine: operation and status codes,
// command struct and key mask helper. No dependencies.
package ghs_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_TRY_INSERT = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [7:0] TAG_FILLED = 8'h80;

  // Classified transaction handed from front to back
  typedef struct packed {
    logic        check;
    logic        insert;
    logic [7:0]  tag;
    logic [63:0] key;
    logic [3:0]  len;
    logic [63:0] key_mask;
    logic [56:0] home;
  } ghs_cmd_t;

  // Byte mask for the valid key bytes, length clamped to the key width
  function automatic logic [63:0] key_mask_f(input logic [3:0] len, input int key_bytes);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < key_bytes && 4'(b) < len) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

/* hw/rtl/ghs_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module ghs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* hw/rtl/ghs_front.sv */
// Front end: takes commands, reduces the hash in its FOLD state, classifies.
// Depends on ghs_pkg.
module ghs_front
  import ghs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy_front,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_key,
  input  logic [3:0]  in_key_length,
  input  logic [63:0] in_key_hash,
  input  logic [3:0]  key_bytes,
  output logic        cmd_valid,
  output ghs_cmd_t    cmd,
  input  logic        cmd_take
);
  // Fold: hash mod (2^57-1) via a 57-bit fold, mod 127 via 7-bit chunks
  typedef enum logic [2:0] {
    F_IDLE = 3'b001, F_FOLD = 3'b010, F_DONE = 3'b100
  } fstate_t;

  fstate_t     state_r;
  logic [63:0] hash_r;
  logic [1:0]  op_r;
  logic [63:0] key_r;
  logic [3:0]  len_r;
  logic [57:0] h57_r;
  logic [10:0] t_r;
  logic [56:0] h1;
  logic [6:0]  t7;
  logic [7:0]  t8;
  logic [63:0] mask;

  assign busy_front = (state_r != F_IDLE);

  // h57: 64-bit fold gives < 2^58; then one compare-subtract gives canonical
  assign h1 = (h57_r >= 58'h1ffffffffffffff) ? 57'(h57_r - 58'h1ffffffffffffff)
                                              : h57_r[56:0];
  // t_r is < 2^11; fold once more then compare-subtract
  assign t8 = {1'b0, t_r[6:0]} + {4'b0, t_r[10:7]};
  assign t7 = (t8 >= 8'd127) ? 7'(t8 - 8'd127) : t8[6:0];
  assign mask = key_mask_f(len_r, int'(key_bytes));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: if (start) state_r <= F_FOLD;
        F_FOLD: state_r <= F_DONE;
        F_DONE: if (cmd_take) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && start) begin
      op_r   <= in_operation;
      key_r  <= in_key;
      len_r  <= in_key_length;
      hash_r <= in_key_hash;
    end
    if (state_r == F_FOLD) begin
      h57_r <= {1'b0, hash_r[56:0]} + {51'b0, hash_r[63:57]};
      // 2^63 mod 127 = 1 chunking: sum of 7-bit chunks of 64 bits
      t_r <= 11'(hash_r[6:0]) + 11'(hash_r[13:7]) + 11'(hash_r[20:14])
           + 11'(hash_r[27:21]) + 11'(hash_r[34:28]) + 11'(hash_r[41:35])
           + 11'(hash_r[48:42]) + 11'(hash_r[55:49]) + 11'(hash_r[62:56])
           + 11'(hash_r[63]);
    end
  end

  assign cmd_valid = (state_r == F_DONE);
  always_comb begin
    cmd.check    = (op_r != OP_INSERT);
    cmd.insert   = (op_r == OP_TRY_INSERT) || (op_r == OP_INSERT);
    cmd.tag      = TAG_FILLED | {1'b0, t7};
    cmd.key      = key_r & mask;
    cmd.len      = len_r;
    cmd.key_mask = mask;
    cmd.home     = h1;
  end
endmodule

/* hw/rtl/ghs_back.sv */
// Back end: clears metadata after reset, then probes slots in turn, one command at a time.
// Depends on ghs_pkg and ghs_ram.
module ghs_back
  import ghs_pkg::*;
#(
  parameter int SLOT_COUNT = 1024,
  parameter int GROUP_SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  ghs_cmd_t   cmd,
  output logic       cmd_take,
  output logic       clearing,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [9:0] out_slot_index
);
  localparam int AW = $clog2(SLOT_COUNT);
  localparam int GROUPS = (SLOT_COUNT + GROUP_SLOTS - 1) / GROUP_SLOTS;
  localparam int TOTAL = GROUPS * GROUP_SLOTS;
  localparam int CW = $clog2(TOTAL + 1);

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001, B_IDLE = 5'b00010, B_READ = 5'b00100,
    B_CHECK = 5'b01000, B_WRITE = 5'b10000
  } bstate_t;

  bstate_t       state_r;
  logic [AW-1:0] addr_r;
  logic [CW-1:0] cnt_r;
  ghs_cmd_t      c_r;
  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    tag_rd, tag_wd;
  logic [63:0]   key_rd;
  logic [3:0]    len_rd;
  logic [AW:0]   start_slot;
  logic [AW:0]   next_addr;
  logic          valid_r;
  logic [1:0]    status_r;
  logic [9:0]    slot_r;

  ghs_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT)) u_tags (
    .clk(clk), .we(we), .addr(addr), .wdata(tag_wd), .rdata(tag_rd));
  ghs_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_keys (
    .clk(clk), .we(we && state_r == B_WRITE), .addr(addr), .wdata(c_r.key),
    .rdata(key_rd));
  ghs_ram #(.WIDTH(4), .DEPTH(SLOT_COUNT)) u_lens (
    .clk(clk), .we(we && state_r == B_WRITE), .addr(addr), .wdata(c_r.len),
    .rdata(len_rd));

  // home slot, group aligned; SLOT_COUNT and GROUP_SLOTS powers of two
  assign start_slot = {1'b0, cmd.home[AW-1:0] & ~AW'(GROUP_SLOTS - 1)};
  assign next_addr = {1'b0, addr_r} + 1'b1;
  assign we = (state_r == B_CLEAR) || (state_r == B_WRITE);
  assign tag_wd = (state_r == B_WRITE) ? c_r.tag : 8'h00;
  assign addr = addr_r;
  assign cmd_take = (state_r == B_IDLE) && cmd_valid;
  assign clearing = (state_r == B_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      addr_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        B_CLEAR: begin
          if (next_addr == (AW+1)'(SLOT_COUNT)) begin
            addr_r  <= '0;
            state_r <= B_IDLE;
          end else begin
            addr_r <= next_addr[AW-1:0];
          end
        end
        B_IDLE: if (cmd_valid) begin
          c_r     <= cmd;
          addr_r  <= start_slot[AW-1:0];
          cnt_r   <= '0;
          state_r <= B_READ;
        end
        B_READ: state_r <= B_CHECK;
        B_CHECK: begin
          if (!tag_rd[7]) begin
            valid_r  <= !c_r.insert;
            status_r <= c_r.insert ? ST_INSERTED : ST_ABSENT;
            slot_r   <= c_r.insert ? 10'(addr_r) : 10'd0;
            state_r  <= c_r.insert ? B_WRITE : B_IDLE;
          end else if (c_r.check && tag_rd == c_r.tag && len_rd == c_r.len
                       && (key_rd & c_r.key_mask) == c_r.key) begin
            valid_r  <= 1'b1;
            status_r <= ST_PRESENT;
            slot_r   <= 10'(addr_r);
            state_r  <= B_IDLE;
          end else if (cnt_r == CW'(TOTAL - 1)) begin
            valid_r  <= 1'b1;
            status_r <= c_r.insert ? ST_FULL : ST_ABSENT;
            slot_r   <= 10'd0;
            state_r  <= B_IDLE;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            addr_r  <= (next_addr == (AW+1)'(SLOT_COUNT)) ? '0 : next_addr[AW-1:0];
            state_r <= B_READ;
          end
        end
        B_WRITE: begin
          valid_r <= 1'b1;
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = valid_r;
  assign out_status = status_r;
  assign out_slot_index = slot_r;
endmodule

/* hw/rtl/grouped_hash_set_engine_top.sv */
// Grouped hash set engine; depends on ghs_pkg, ghs_front, ghs_back.
// Result: the strobe follows a READ and a CHECK state for each probed slot,
// and a WRITE state when an insert writes. The back end takes one transaction
// at a time while the front holds the next.
// Reset: a clearing pass zeroes all tags, busy high meanwhile. Results show
// one cycle on out_valid; the receiver cannot stall.
module grouped_hash_set_engine_top
  import ghs_pkg::*;
#(
  parameter int SLOT_COUNT = 1024,
  parameter int GROUP_SLOTS = 32,
  parameter int KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_key,
  input  logic [3:0]  in_key_length,
  input  logic [63:0] in_key_hash,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [9:0]  out_slot_index
);
  logic     busy_front, cmd_valid, cmd_take, clearing;
  ghs_cmd_t cmd;

  assign busy = busy_front || clearing;

  ghs_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start && !clearing), .busy_front(busy_front),
    .in_operation(in_operation), .in_key(in_key), .in_key_length(in_key_length),
    .in_key_hash(in_key_hash), .key_bytes(4'(KEY_BYTES)),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take));

  ghs_back #(.SLOT_COUNT(SLOT_COUNT), .GROUP_SLOTS(GROUP_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .clearing(clearing), .out_valid(out_valid),
    .out_status(out_status), .out_slot_index(out_slot_index));
endmodule

/* hw/rtl/ghs_checker.sv */
// Port-level checker for the grouped hash set engine, bound to the top.
// Depends on ghs_pkg.
module ghs_checker
  import ghs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [9:0] out_slot_index
);
  // Acceptance always makes the block busy next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  // Absent and full carry slot zero
  a_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ABSENT || out_status == ST_FULL)
    |-> out_slot_index == 10'd0) else $error("nonzero slot");
  // A result strobe lasts a single cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe held");
endmodule

bind grouped_hash_set_engine_top ghs_checker u_ghs_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_slot_index(out_slot_index));

/* tb/sv/tb.sv */
// Testbench for grouped_hash_set_engine_top: drives lookups and inserts,
// predicts status and slot from its own copy of the tag/key store.
// Depends on ghs_pkg and the engine RTL.
`timescale 1ns / 1ps

class hash_set_scoreboard;
  logic [7:0]  tags [1024];
  logic [63:0] keys [1024];
  logic [3:0]  lens [1024];
  logic [1:0]  status_q [$];
  logic [9:0]  slot_q [$];
  int mismatches;
  int results;
  int n_present, n_inserted, n_absent, n_full;

  function new();
    foreach (tags[i]) tags[i] = 8'h00;
    mismatches = 0;
    results = 0;
  endfunction

  // Compute the expected answer and update the mirrored table
  function void note_command(logic [1:0] op, logic [63:0] key_in, logic [3:0] len,
                             logic [63:0] hash);
    logic [63:0] mask;
    logic [63:0] key;
    logic [63:0] home;
    logic [7:0]  tag;
    logic [9:0]  base;
    logic [9:0]  s;
    bit check, ins, done;
    int nb;
    nb = (len < 8) ? len : 8;
    mask = (nb >= 8) ? '1 : ((64'd1 << (nb * 8)) - 1);
    key = key_in & mask;
    home = hash % 64'h1ffffffffffffff;
    tag = 8'((hash % 64'h7f) | 64'h80);
    base = 10'(home % 1024);
    base = base & ~10'd31;
    check = (op != ghs_pkg::OP_INSERT);
    ins = (op == ghs_pkg::OP_TRY_INSERT) || (op == ghs_pkg::OP_INSERT);
    done = 0;
    for (int g = 0; g < 32 && !done; g++) begin
      for (int k = 0; k < 32 && !done; k++) begin
        s = 10'(base + g * 32 + k);
        if ((tags[s] & ghs_pkg::TAG_FILLED) == 0) begin
          done = 1;
          if (ins) begin
            tags[s] = tag; keys[s] = key; lens[s] = len;
            status_q.push_back(ghs_pkg::ST_INSERTED); slot_q.push_back(s);
          end else begin
            status_q.push_back(ghs_pkg::ST_ABSENT); slot_q.push_back('0);
          end
        end else if (check && tags[s] == tag && lens[s] == len &&
                     (keys[s] & mask) == key) begin
          done = 1;
          status_q.push_back(ghs_pkg::ST_PRESENT); slot_q.push_back(s);
        end
      end
    end
    if (!done) begin
      status_q.push_back(ins ? ghs_pkg::ST_FULL : ghs_pkg::ST_ABSENT);
      slot_q.push_back('0);
    end
  endfunction

  function void check_result(logic [1:0] st, logic [9:0] slot);
    logic [1:0] es;
    logic [9:0] eslot;
    results++;
    if (status_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: status=%0d slot=%0d", st, slot);
      return;
    end
    es = status_q.pop_front();
    eslot = slot_q.pop_front();
    case (es)
      ghs_pkg::ST_PRESENT:  n_present++;
      ghs_pkg::ST_INSERTED: n_inserted++;
      ghs_pkg::ST_ABSENT:   n_absent++;
      default:              n_full++;
    endcase
    if (st !== es || slot !== eslot) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: status exp=%0d got=%0d, slot exp=%0d got=%0d",
                 es, st, eslot, slot);
    end
  endfunction
endclass

module tb;
  import ghs_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [63:0] in_key = '0;
  logic [3:0]  in_key_length = '0;
  logic [63:0] in_key_hash = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [9:0]  out_slot_index;

  hash_set_scoreboard sb = new();
  int idle_pct = 30;
  logic [63:0] key_pool [64];
  logic [63:0] hash_pool [64];
  logic [3:0]  len_pool [64];

  always #6 clk = ~clk;

  grouped_hash_set_engine_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key(in_key), .in_key_length(in_key_length),
    .in_key_hash(in_key_hash), .out_valid(out_valid), .out_status(out_status),
    .out_slot_index(out_slot_index)
  );

  // Results cannot be held off; check every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_slot_index);
  end

  // Issue one command; random idle cycles drop start before it
  task automatic send_cmd(logic [1:0] op, logic [63:0] key, logic [3:0] len,
                          logic [63:0] hash);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_operation <= op;
    in_key <= key;
    in_key_length <= len;
    in_key_hash <= hash;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(op, key, len, hash);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Draw a key from the reused pool most of the time so lookups hit
  task automatic random_cmd();
    int p;
    logic [1:0] op;
    p = $urandom_range(63);
    op = 2'($urandom_range(3));
    if ($urandom_range(9) < 8)
      send_cmd(op, key_pool[p], len_pool[p], hash_pool[p]);
    else
      send_cmd(op, rand64(), 4'($urandom_range(15)), rand64());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (key_pool[i]) begin
      key_pool[i] = rand64();
      len_pool[i] = 4'($urandom_range(15));
      // the first 16 pool entries take hashes whose low ten bits are their index
      hash_pool[i] = (i < 16) ? {rand64() & ~64'h3ff} | 64'(i) : rand64();
    end

    // Directed: extremes, every operation, length edges, duplicates
    send_cmd(OP_LOOKUP, '0, 4'd0, '0);
    send_cmd(OP_TRY_INSERT, '0, 4'd0, '0);
    send_cmd(OP_TRY_INSERT, '0, 4'd0, '0);
    send_cmd(OP_LOOKUP, 64'hffff, 4'd0, '0);
    send_cmd(OP_INSERT, '0, 4'd0, '0);
    send_cmd(OP_TRY_INSERT, '1, 4'd8, '1);
    send_cmd(OP_LOOKUP, '1, 4'd8, '1);
    send_cmd(OP_TRY_INSERT, '1, 4'd15, '1);
    send_cmd(OP_LOOKUP, '1, 4'd15, '1);
    send_cmd(OP_LOOKUP, '1, 4'd9, '1);
    send_cmd(OP_TRY_INSERT, 64'h1234_5678_9abc_def0, 4'd3, 64'h1ffffffffffffff);
    send_cmd(OP_LOOKUP, 64'h0000_0000_00bc_def0, 4'd3, 64'h1ffffffffffffff);
    send_cmd(OP_LOOKUP, 64'h0000_0000_00bc_def0, 4'd2, 64'h1ffffffffffffff);
    send_cmd(2'd3, 64'h00bc_def0, 4'd3, 64'h1ffffffffffffff);
    send_cmd(OP_TRY_INSERT, 64'h5a, 4'd1, 64'h7f);
    send_cmd(OP_TRY_INSERT, 64'h5b, 4'd1, 64'h7f);
    send_cmd(OP_LOOKUP, 64'h5b, 4'd1, 64'h7f);
    send_cmd(OP_INSERT, 64'h5a, 4'd1, 64'h7f);
    send_cmd(OP_LOOKUP, 64'h5a, 4'd1, 64'h3e0);

    // Random phases with changing idle pattern
    for (int n = 0; n < 900; n++) begin
      if (n == 300) idle_pct = 56;
      if (n == 600) idle_pct = 0;
      random_cmd();
    end
    // Fill the table to reach the full case, then probe it
    idle_pct = 0;
    for (int n = 0; n < 750; n++) send_cmd(OP_INSERT, rand64(), 4'd8, rand64());
    for (int n = 0; n < 30; n++) random_cmd();
    start <= 0;

    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d results: %0d inserted, %0d present, %0d absent, %0d full",
             sb.results, sb.n_inserted, sb.n_present, sb.n_absent, sb.n_full);
    if (sb.mismatches == 0 && sb.status_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("mismatches: %0d", sb.mismatches);
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog; slowest run is about 1700 items of full table sweeps
  initial begin
    #250_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
